/* rtl/led_matrix_blink_scanner_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the LED matrix blink scanner
// Shared clocking and reset gating for the concurrent checks of the core.
// ---------------------------------------------------------------------------
`ifndef LED_MATRIX_BLINK_SCANNER_CORE_MACROS_SVH
`define LED_MATRIX_BLINK_SCANNER_CORE_MACROS_SVH

// Check a property on every rising edge of clk while out of reset
`define LMBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define LMBS_ASSERT_IMPL(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/lmbs_pkg.sv */
// ---------------------------------------------------------------------------
// LED matrix blink scanner package
// Operation codes, sequencer states and the beat types of both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmbs_pkg;

	localparam int NUM_COLS = 8;
	localparam int COL_W    = $clog2(NUM_COLS);
	localparam int ROW_W    = 3;
	localparam int PIX_W    = 8;

	localparam logic [7:0] HALF_PERIOD_RESET = 8'd10;
	localparam logic [7:0] BUZZER_BIT_MASK   = 8'hFE;

	typedef enum logic [2:0] {
		OP_CLEAR     = 3'd0,
		OP_SET       = 3'd1,
		OP_BLINK_ON  = 3'd2,
		OP_BLINK_OFF = 3'd3,
		OP_TICK      = 3'd4,
		OP_FILL_ALL  = 3'd5,
		OP_CLEAR_ALL = 3'd6,
		OP_END_BLINK = 3'd7
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} state_t;

	typedef struct packed {
		op_t              operation;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             buzzer_on;
		logic             audio_on;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]       column_select;
		logic [PIX_W-1:0] pixel_data;
		logic             last_column;
	} out_beat_t;

endpackage

`default_nettype wire

/* rtl/led_matrix_blink_scanner_core.sv */
// Timing: a tick presents its first column beat in the cycle after it is accepted, then one
//   column beat per cycle while out_stall is low: eight beats per tick.
// Input stays stalled for the whole scan, so no command is taken until the last column beat
//   of a tick is taken. The column sequencer and its shared blink update unit serve one tick at a time.
// Reset (arst_n low): pixel store, blink mask, timer, phase and pending end clear at once;
//   half period returns to 10 ticks.
// ---------------------------------------------------------------------------
// LED matrix blink scanner core
// Pixel store and blink mask for an 8x8 matrix; a tick scans the columns one
// beat at a time and, on a flip, applies the blink update to each column.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "led_matrix_blink_scanner_core_macros.svh"

module led_matrix_blink_scanner_core
	import lmbs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire in_beat_t   in_data,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      out_beat_t  out_data,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data
);

	state_t state_q;
	state_t state_d;

	logic [PIX_W-1:0] pixel_store_q [NUM_COLS];
	logic [PIX_W-1:0] blink_mask_q  [NUM_COLS];
	logic [7:0]       half_period_q;
	logic [7:0]       tick_count_q;
	logic             blink_phase_q;
	logic             end_pending_q;

	// per-tick context held by the column sequencer
	logic [COL_W-1:0] col_q;
	logic             flip_q;
	logic             end_q;
	logic             buzz_q;
	logic             audio_q;

	logic       in_fire;
	logic       out_fire;
	logic       last_col;
	logic [8:0] tick_next;
	logic       flip;

	logic [PIX_W-1:0] scan_pix;
	logic [PIX_W-1:0] scan_mask;
	logic [PIX_W-1:0] upd_pix;

	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;
	assign last_col = (col_q == COL_W'(NUM_COLS - 1));

	// timer compare for the tick being accepted; zero half period flips every tick
	assign tick_next = {1'b0, tick_count_q} + 9'd1;
	assign flip      = (tick_next >= {1'b0, half_period_q});

	// shared blink update unit, applied to the column under scan
	assign scan_pix  = pixel_store_q[col_q];
	assign scan_mask = blink_mask_q[col_q];
	assign upd_pix   = blink_phase_q ? (scan_pix | scan_mask) : (scan_pix & ~scan_mask);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_data.operation == OP_TICK) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (out_fire && last_col) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: in_stall  = 1'b0;
			ST_SCAN: out_valid = 1'b1;
			default: in_stall  = 1'b1;
		endcase
		out_data.column_select = ((8'd1 << col_q) & BUZZER_BIT_MASK) | {7'd0, buzz_q};
		out_data.pixel_data    = scan_pix | {7'd0, audio_q};
		out_data.last_column   = last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_wr_en) begin
			half_period_q <= cfg_wr_data;
		end
	end

	// commands, tick start and per-column blink update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COLS; i++) begin
				pixel_store_q[i] <= '0;
				blink_mask_q[i]  <= '0;
			end
			tick_count_q  <= '0;
			blink_phase_q <= 1'b0;
			end_pending_q <= 1'b0;
			col_q         <= '0;
			flip_q        <= 1'b0;
			end_q         <= 1'b0;
			buzz_q        <= 1'b0;
			audio_q       <= 1'b0;
		end else begin
			if (in_fire) begin
				case (in_data.operation)
					OP_CLEAR: pixel_store_q[in_data.column][in_data.row] <= 1'b0;
					OP_SET:   pixel_store_q[in_data.column][in_data.row] <= 1'b1;
					OP_BLINK_ON: begin
						blink_mask_q[in_data.column][in_data.row] <= 1'b1;
						tick_count_q  <= '0;
						end_pending_q <= 1'b0;
					end
					OP_BLINK_OFF: begin
						blink_mask_q[in_data.column][in_data.row]  <= 1'b0;
						pixel_store_q[in_data.column][in_data.row] <= 1'b0;
					end
					OP_TICK: begin
						col_q   <= '0;
						buzz_q  <= in_data.buzzer_on;
						audio_q <= in_data.audio_on;
						flip_q  <= flip;
						end_q   <= flip && end_pending_q;
						if (flip) begin
							tick_count_q  <= '0;
							blink_phase_q <= end_pending_q ? 1'b0 : !blink_phase_q;
							end_pending_q <= 1'b0;
						end else begin
							tick_count_q <= tick_next[7:0];
						end
					end
					OP_FILL_ALL: begin
						for (int i = 0; i < NUM_COLS; i++) begin
							pixel_store_q[i] <= '1;
						end
					end
					OP_CLEAR_ALL: begin
						for (int i = 0; i < NUM_COLS; i++) begin
							pixel_store_q[i] <= '0;
						end
					end
					OP_END_BLINK: end_pending_q <= 1'b1;
					default: end_pending_q <= end_pending_q;
				endcase
			end
			// advance the scan once the column beat is taken
			if (out_fire) begin
				if (flip_q) begin
					pixel_store_q[col_q] <= upd_pix;
				end
				if (end_q) begin
					blink_mask_q[col_q] <= '0;
				end
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	`LMBS_ASSERT(a_tick_starts_scan,
		(in_fire && in_data.operation == OP_TICK) |=> (out_valid && col_q == '0),
		"tick did not start a scan at column zero")
	`LMBS_ASSERT(a_last_ends_scan,
		(out_fire && out_data.last_column) |=> !out_valid,
		"scan continued past the last column")
	`LMBS_ASSERT_IMPL(a_select_onehot, out_valid,
		$onehot0(out_data.column_select[7:1]),
		"column select has more than one column bit")
	`LMBS_ASSERT_IMPL(a_end_consumed, out_valid && end_q,
		!end_pending_q && !blink_phase_q,
		"pending end not consumed by the flip")
	`LMBS_ASSERT(a_hold_while_scan,
		(out_valid && out_stall) |=> $stable(col_q),
		"scan column moved under stall")

endmodule

`default_nettype wire

/* test/led_matrix_blink_scanner_core_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED matrix blink scanner core testbench
// Drives pixel, blink and tick commands through the input channel in random
// bursts. A predictor of the pixel store, the blink mask and the
// blink timer builds the column beats of every tick, and a monitor checks
// each output beat field by field. The half period is changed between phases.
// ---------------------------------------------------------------------------

module led_matrix_blink_scanner_core_tb;

	import lmbs_pkg::*;

	localparam int CLK_HALF_NS   = 4;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int DRAIN_CYCLES  = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_TRIGGER  = 80;
	localparam int RANDOM_PHASE  = 41;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	in_beat_t   in_data     = '0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	out_beat_t  out_data;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;

	// Commands waiting for the driver and column beats waiting for the DUT
	in_beat_t  pending_cmds[$];
	out_beat_t expected_scans[$];

	// Predicted block state
	logic [7:0] pixel_model [NUM_COLS];
	logic [7:0] mask_model  [NUM_COLS];
	logic [7:0] tick_model;
	logic       phase_model;
	logic       end_pending_model;
	logic [7:0] half_period;

	int errors        = 0;
	int cmds_accepted = 0;
	int beats_checked = 0;
	int ticks_seen    = 0;
	int settings_used = 0;
	int cycle_count   = 0;

	// Sender burst state and receiver pattern state
	int  burst_left = 1;
	int  gap_left   = 0;
	int  hold_left  = 0;
	bit  hold_done  = 1'b0;
	int  stall_mode = 0;
	int  mode_left  = 0;

	led_matrix_blink_scanner_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#CLK_HALF_NS clk = 1'b1;
		#CLK_HALF_NS clk = 1'b0;
	end

	// Apply one accepted command to the predicted state; a tick queues its scan
	task automatic apply_command(input in_beat_t cmd);
		logic [7:0] row_bit;
		logic [8:0] next_count;
		out_beat_t  beat;
		row_bit = 8'd1 << cmd.row;
		case (cmd.operation)
			OP_CLEAR: pixel_model[cmd.column] &= ~row_bit;
			OP_SET: pixel_model[cmd.column] |= row_bit;
			OP_BLINK_ON: begin
				mask_model[cmd.column] |= row_bit;
				tick_model = 8'd0;
				end_pending_model = 1'b0;
			end
			OP_BLINK_OFF: begin
				mask_model[cmd.column] &= ~row_bit;
				pixel_model[cmd.column] &= ~row_bit;
			end
			OP_FILL_ALL: for (int c = 0; c < NUM_COLS; c++) pixel_model[c] = 8'hFF;
			OP_CLEAR_ALL: for (int c = 0; c < NUM_COLS; c++) pixel_model[c] = 8'h00;
			OP_END_BLINK: end_pending_model = 1'b1;
			OP_TICK: begin
				ticks_seen++;
				// Scan the store as it stands before this tick's blink update
				for (int c = 0; c < NUM_COLS; c++) begin
					beat.column_select = ((8'd1 << c) & BUZZER_BIT_MASK) | {7'd0, cmd.buzzer_on};
					beat.pixel_data    = pixel_model[c] | {7'd0, cmd.audio_on};
					beat.last_column   = (c == NUM_COLS - 1);
					expected_scans.push_back(beat);
				end
				// Advance the timer; flip the phase at the half period
				next_count = {1'b0, tick_model} + 9'd1;
				if (next_count < {1'b0, half_period}) begin
					tick_model = next_count[7:0];
				end else begin
					tick_model = 8'd0;
					phase_model = ~phase_model;
					if (end_pending_model)
						phase_model = 1'b0;
					for (int c = 0; c < NUM_COLS; c++) begin
						if (phase_model)
							pixel_model[c] |= mask_model[c];
						else
							pixel_model[c] &= ~mask_model[c];
					end
					if (end_pending_model) begin
						end_pending_model = 1'b0;
						for (int c = 0; c < NUM_COLS; c++) mask_model[c] = 8'h00;
					end
				end
			end
			default: ;
		endcase
	endtask

	// Track register writes and accepted commands
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				pixel_model[c] = 8'h00;
				mask_model[c]  = 8'h00;
			end
			tick_model        = 8'd0;
			phase_model       = 1'b0;
			end_pending_model = 1'b0;
			half_period       = HALF_PERIOD_RESET;
		end else begin
			if (cfg_wr_en)
				half_period = cfg_wr_data;
			if (in_valid && !in_stall) begin
				apply_command(in_data);
				cmds_accepted <= cmds_accepted + 1;
			end
		end
	end

	// Driver: offer queued commands in bursts with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0 || pending_cmds.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				in_valid <= 1'b0;
			end else begin
				in_data  <= pending_cmds.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// Receiver: one long hold-off, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && cmds_accepted >= HOLD_TRIGGER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(16, 64);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 99) < 30);
				2: out_stall <= ($urandom_range(0, 99) < 75);
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	// Monitor: compare each output beat with the oldest expected column beat
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_scans.size() == 0) begin
				$display("%0t: unexpected column beat, expected none, actual %h", $time, out_data);
				errors++;
			end else begin
				want = expected_scans.pop_front();
				beats_checked++;
				if (out_data.column_select !== want.column_select) begin
					$display("%0t: column_select mismatch, expected %h, actual %h",
						$time, want.column_select, out_data.column_select);
					errors++;
				end
				if (out_data.pixel_data !== want.pixel_data) begin
					$display("%0t: pixel_data mismatch, expected %h, actual %h",
						$time, want.pixel_data, out_data.pixel_data);
					errors++;
				end
				if (out_data.last_column !== want.last_column) begin
					$display("%0t: last_column mismatch, expected %b, actual %b",
						$time, want.last_column, out_data.last_column);
					errors++;
				end
			end
		end
	end

	// Bound the run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	task automatic push_cmd(input op_t op, input int col, input int row,
		input bit buzz, input bit audio);
		in_beat_t cmd;
		cmd.operation = op;
		cmd.column    = col[COL_W-1:0];
		cmd.row       = row[ROW_W-1:0];
		cmd.buzzer_on = buzz;
		cmd.audio_on  = audio;
		pending_cmds.push_back(cmd);
	endtask

	// Random pixel field values, also used where an operation ignores them
	function automatic int any_idx();
		return $urandom_range(0, 7);
	endfunction

	// Wait until every command is taken and every beat has come, then drain
	task automatic wait_idle();
		while (pending_cmds.size() != 0 || in_valid || expected_scans.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_half_period(input logic [7:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		settings_used++;
	endtask

	// Mostly pixel edits and ticks, with blink control mixed in
	task automatic push_random_cmds(input int count);
		int   pick;
		op_t  op;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 38)
				op = OP_TICK;
			else if (pick < 52)
				op = OP_SET;
			else if (pick < 62)
				op = OP_CLEAR;
			else if (pick < 74)
				op = OP_BLINK_ON;
			else if (pick < 82)
				op = OP_BLINK_OFF;
			else if (pick < 87)
				op = OP_FILL_ALL;
			else if (pick < 92)
				op = OP_CLEAR_ALL;
			else
				op = OP_END_BLINK;
			push_cmd(op, any_idx(), any_idx(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: flip on every tick so blink effects show at once
		write_half_period(8'd1);
		push_cmd(OP_TICK, 0, 0, 1'b0, 1'b0);
		push_cmd(OP_TICK, 7, 7, 1'b1, 1'b1);
		push_cmd(OP_SET, 0, 0, 1'b0, 1'b0);
		push_cmd(OP_SET, 7, 7, 1'b1, 1'b1);
		push_cmd(OP_SET, 3, 5, 1'b0, 1'b1);
		push_cmd(OP_CLEAR, 3, 5, 1'b1, 1'b0);
		push_cmd(OP_SET, 3, 6, 1'b0, 1'b0);
		push_cmd(OP_TICK, any_idx(), any_idx(), 1'b1, 1'b0);
		push_cmd(OP_FILL_ALL, any_idx(), any_idx(), 1'b1, 1'b1);
		push_cmd(OP_TICK, any_idx(), any_idx(), 1'b0, 1'b1);
		push_cmd(OP_CLEAR_ALL, any_idx(), any_idx(), 1'b1, 1'b1);
		push_cmd(OP_SET, 1, 2, 1'b0, 1'b0);
		push_cmd(OP_BLINK_ON, 1, 2, 1'b0, 1'b0);
		push_cmd(OP_BLINK_ON, 4, 0, 1'b1, 1'b1);
		push_cmd(OP_TICK, any_idx(), any_idx(), 1'b0, 1'b0);
		push_cmd(OP_TICK, any_idx(), any_idx(), 1'b0, 1'b0);
		// Fill keeps the mask; the next flip writes the phase over it
		push_cmd(OP_FILL_ALL, 0, 0, 1'b0, 1'b0);
		push_cmd(OP_TICK, any_idx(), any_idx(), 1'b0, 1'b0);
		push_cmd(OP_BLINK_OFF, 4, 0, 1'b0, 1'b0);
		// Pending end forces the phase off and empties the mask
		push_cmd(OP_END_BLINK, any_idx(), any_idx(), 1'b1, 1'b0);
		push_cmd(OP_TICK, any_idx(), any_idx(), 1'b0, 1'b0);
		push_cmd(OP_TICK, any_idx(), any_idx(), 1'b1, 1'b1);
		wait_idle();

		// Zero half period acts like one
		write_half_period(8'd0);
		push_cmd(OP_BLINK_ON, 5, 5, 1'b0, 1'b0);
		push_cmd(OP_TICK, any_idx(), any_idx(), 1'b0, 1'b0);
		push_cmd(OP_TICK, any_idx(), any_idx(), 1'b0, 1'b0);
		push_cmd(OP_TICK, any_idx(), any_idx(), 1'b1, 1'b0);
		wait_idle();

		// Random phases across several half periods, extremes included
		write_half_period(HALF_PERIOD_RESET);
		push_random_cmds(RANDOM_PHASE);
		wait_idle();
		write_half_period(8'd255);
		push_random_cmds(RANDOM_PHASE);
		wait_idle();
		write_half_period(8'd2);
		push_random_cmds(RANDOM_PHASE);
		wait_idle();
		write_half_period(8'($urandom_range(3, 8)));
		push_random_cmds(RANDOM_PHASE);
		wait_idle();
		write_half_period(8'd1);
		push_random_cmds(RANDOM_PHASE);
		wait_idle();

		$display("covered %0d commands and %0d ticks, %0d column beats checked",
			cmds_accepted, ticks_seen, beats_checked);
		$display("over %0d half period settings, with one long output hold-off", settings_used);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
